// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/sm2_alu_pkg.sv =====
// Package: SM2 field constants, opcodes and limb helpers.
`timescale 1ns / 1ps
`default_nettype none
package sm2_alu_pkg;
  localparam int LimbW = 64;
  localparam int NumLimbs = 4;
  localparam int FieldW = LimbW * NumLimbs;
  localparam int CmdW = 3;
  localparam logic [FieldW-1:0] Prime =
    256'hFFFFFFFEFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF00000000FFFFFFFFFFFFFFFF;
  localparam logic [FieldW-1:0] Expo =
    256'hFFFFFFFEFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF00000000FFFFFFFFFFFFFFFD;
  localparam logic [CmdW-1:0] CmdAdd = 3'd0;
  localparam logic [CmdW-1:0] CmdSub = 3'd1;
  localparam logic [CmdW-1:0] CmdNeg = 3'd2;
  localparam logic [CmdW-1:0] CmdMul = 3'd3;
  localparam logic [CmdW-1:0] CmdSqr = 3'd4;
  localparam logic [CmdW-1:0] CmdInv = 3'd5;
  // Power table: 16 entries, addressed by a 4-bit window.
  localparam int TabDepth = 16;
  localparam int TabAw = 4;
  // Windows of the exponent: 64.
  localparam int NumWin = FieldW / TabAw;
  localparam int WinCntW = 6;
  // Multiply/reduce unit request and response.
  typedef struct packed {
    logic             start;
    logic [FieldW-1:0] x;
    logic [FieldW-1:0] y;
  } mreq_t;
  typedef struct packed {
    logic             done;
    logic [FieldW-1:0] r;
  } mrsp_t;
endpackage
`default_nettype wire

// ===== sv/sm2_alu_if.sv =====
// Valid/ready channel interfaces for the SM2 field ALU.
`timescale 1ns / 1ps
`default_nettype none
interface sm2_alu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [63:0] a_limb0, a_limb1, a_limb2, a_limb3;
  logic [63:0] b_limb0, b_limb1, b_limb2, b_limb3;
  modport source(output valid, cmd, a_limb0, a_limb1, a_limb2, a_limb3,
                 b_limb0, b_limb1, b_limb2, b_limb3, input ready);
  modport sink(input valid, cmd, a_limb0, a_limb1, a_limb2, a_limb3,
               b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

interface sm2_alu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_limb0, res_limb1, res_limb2, res_limb3;
  modport source(output valid, res_limb0, res_limb1, res_limb2, res_limb3,
                 input ready);
  modport sink(input valid, res_limb0, res_limb1, res_limb2, res_limb3,
               output ready);
endinterface
`default_nettype wire

// ===== sv/sm2_alu_mulred.sv =====
// Modular multiplier: 64 partial products on one 32x32 multiplier, then fold.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sm2_alu_mulred (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sm2_alu_pkg::mreq_t req,
  output sm2_alu_pkg::mrsp_t      rsp
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_FOLD, S_SUB1, S_SUB2} st_t;
  st_t state;
  logic [sm2_alu_pkg::FieldW-1:0] x, y;
  logic [5:0] idx;
  logic [63:0] prod;
  logic [2*sm2_alu_pkg::FieldW+63:0] acc;
  logic [2*sm2_alu_pkg::FieldW+63:0] fold;
  logic [2:0] ai, bi;
  logic [3:0] sh;
  logic [31:0] xa, yb;

  // 32-bit digit select: idx walks all 8x8 digit pairs
  assign ai = idx[5:3];
  assign bi = idx[2:0];
  assign sh = {1'b0, ai} + {1'b0, bi};
  assign xa = x[{ai, 5'd0} +: 32];
  assign yb = y[{bi, 5'd0} +: 32];

  // Fold of the high part h: 2^256 == 2^224 + 2^96 - 2^64 + 1 (mod p).
  function automatic logic [2*sm2_alu_pkg::FieldW+63:0] fold_f(
      input logic [2*sm2_alu_pkg::FieldW+63:0] v);
    logic [2*sm2_alu_pkg::FieldW+63:0] lo, h;
    begin
      lo = {{(sm2_alu_pkg::FieldW+64){1'b0}}, v[sm2_alu_pkg::FieldW-1:0]};
      h = {{sm2_alu_pkg::FieldW{1'b0}},
           v[2*sm2_alu_pkg::FieldW+63:sm2_alu_pkg::FieldW]};
      fold_f = lo + h + (h << 96) + (h << 224) - (h << 64);
    end
  endfunction

  assign fold = fold_f(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            x <= req.x;
            y <= req.y;
            idx <= '0;
            acc <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // each partial product is registered and accumulated before the next is formed
          prod <= xa * yb;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + ({{(2*sm2_alu_pkg::FieldW){1'b0}}, prod} << {sh, 5'd0});
          idx <= idx + 6'd1;
          state <= (idx == 6'd63) ? S_FOLD : S_MUL;
        end
        S_FOLD: begin
          // repeat until nothing is left above bit 255
          acc <= fold;
          if (fold[2*sm2_alu_pkg::FieldW+63:sm2_alu_pkg::FieldW] == '0) state <= S_SUB1;
        end
        S_SUB1: begin
          if (acc[255:0] >= sm2_alu_pkg::Prime)
            acc[255:0] <= acc[255:0] - sm2_alu_pkg::Prime;
          state <= S_SUB2;
        end
        S_SUB2: begin
          if (acc[255:0] >= sm2_alu_pkg::Prime)
            rsp.r <= acc[255:0] - sm2_alu_pkg::Prime;
          else
            rsp.r <= acc[255:0];
          rsp.done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_done_idle, clk, rst, rsp.done, state == S_IDLE, "done outside idle")
  `CHK_NEXT(a_start_run, clk, rst, req.start && state == S_IDLE, state == S_MUL, "start lost")
  `CHK_IMPL(a_acc_idx, clk, rst, state == S_FOLD, idx == 6'd0, "fold before all products")
endmodule
`default_nettype wire

// ===== sv/sm2_alu_ctrl.sv =====
// Sequencer: add/sub/neg datapath, power table memory and inversion ladder.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sm2_alu_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  sm2_alu_in_if.sink   in_ch,
  sm2_alu_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_MWAIT, S_TBL, S_SQR, S_RD, S_RDW, S_WMUL, S_DONE
  } st_t;
  st_t state;
  sm2_alu_pkg::mreq_t mreq;
  sm2_alu_pkg::mrsp_t mrsp;
  logic [sm2_alu_pkg::FieldW-1:0] a, acc, res;
  logic [sm2_alu_pkg::TabAw-1:0] tix;
  logic [sm2_alu_pkg::WinCntW-1:0] win;
  logic [1:0] sq;
  logic busy_mul;
  logic inv_acc;
  // power table memory
  logic [sm2_alu_pkg::FieldW-1:0] tab [sm2_alu_pkg::TabDepth];
  logic [sm2_alu_pkg::FieldW-1:0] tab_rd;
  logic tab_we;
  logic [sm2_alu_pkg::TabAw-1:0] tab_wa, tab_ra;
  logic [sm2_alu_pkg::FieldW-1:0] tab_wd;
  logic [sm2_alu_pkg::FieldW-1:0] ain, bin;
  logic [sm2_alu_pkg::FieldW:0] sum, dif, sump, ndif;
  logic [sm2_alu_pkg::FieldW-1:0] addr, subr, negr;

  sm2_alu_mulred u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  always_ff @(posedge clk) begin
    if (tab_we) tab[tab_wa] <= tab_wd;
    tab_rd <= tab[tab_ra];
  end

  // add/sub/neg one-shot datapath
  assign ain = {in_ch.a_limb3, in_ch.a_limb2, in_ch.a_limb1, in_ch.a_limb0};
  assign bin = {in_ch.b_limb3, in_ch.b_limb2, in_ch.b_limb1, in_ch.b_limb0};
  assign sum = {1'b0, ain} + {1'b0, bin};
  assign sump = sum - {1'b0, sm2_alu_pkg::Prime};
  assign addr = (sum[256] || !sump[256]) ? sump[255:0] : sum[255:0];
  assign dif = {1'b0, ain} - {1'b0, bin};
  assign subr = dif[256] ? dif[255:0] + sm2_alu_pkg::Prime : dif[255:0];
  // neg is p - a with the same borrow correction as sub
  assign ndif = {1'b0, sm2_alu_pkg::Prime} - {1'b0, ain};
  assign negr = (ain == '0) ? '0 :
                ndif[256] ? ndif[255:0] + sm2_alu_pkg::Prime : ndif[255:0];

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign busy_mul = 1'b0;
  assign inv_acc = in_ch.valid && in_ch.ready && (in_ch.cmd == sm2_alu_pkg::CmdInv);
  assign {out_ch.res_limb3, out_ch.res_limb2, out_ch.res_limb1, out_ch.res_limb0} = res;

  // exponent window for the current step, highest first
  logic [sm2_alu_pkg::TabAw-1:0] ewin;
  assign ewin = sm2_alu_pkg::Expo[win*sm2_alu_pkg::TabAw +: sm2_alu_pkg::TabAw];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      mreq.start <= 1'b0;
      tab_we <= 1'b0;
    end else begin
      mreq.start <= 1'b0;
      tab_we <= 1'b0;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            a <= ain;
            case (in_ch.cmd)
              sm2_alu_pkg::CmdAdd: begin res <= addr; out_ch.valid <= 1'b1; end
              sm2_alu_pkg::CmdSub: begin res <= subr; out_ch.valid <= 1'b1; end
              sm2_alu_pkg::CmdNeg: begin res <= negr; out_ch.valid <= 1'b1; end
              sm2_alu_pkg::CmdMul: begin
                mreq.x <= ain; mreq.y <= bin; mreq.start <= 1'b1; state <= S_MWAIT;
              end
              sm2_alu_pkg::CmdSqr: begin
                mreq.x <= ain; mreq.y <= ain; mreq.start <= 1'b1; state <= S_MWAIT;
              end
              sm2_alu_pkg::CmdInv: begin
                // fill table: entry 0 = 1, entry 1 = a, then a^k by multiplies
                tab_we <= 1'b1; tab_wa <= '0; tab_wd <= 256'd1;
                acc <= ain; tix <= 4'd1;
                state <= S_TBL;
              end
              default: begin res <= '0; out_ch.valid <= 1'b1; end
            endcase
          end
        end
        S_MWAIT: begin
          if (mrsp.done) begin res <= mrsp.r; out_ch.valid <= 1'b1; state <= S_IDLE; end
        end
        S_TBL: begin
          // write a^tix, then start a^(tix+1) unless table complete
          if (tix == 4'd1 || mrsp.done) begin
            tab_we <= 1'b1; tab_wa <= tix;
            tab_wd <= (tix == 4'd1) ? acc : mrsp.r;
            if (tix == 4'd15) begin
              acc <= 256'd1; win <= sm2_alu_pkg::WinCntW'(sm2_alu_pkg::NumWin - 1);
              sq <= '0;
              mreq.x <= 256'd1; mreq.y <= 256'd1; mreq.start <= 1'b1;
              state <= S_SQR;
            end else begin
              if (tix != 4'd1) acc <= mrsp.r;
              mreq.x <= (tix == 4'd1) ? acc : mrsp.r; mreq.y <= a; mreq.start <= 1'b1;
              tix <= tix + 4'd1;
            end
          end
        end
        S_SQR: begin
          if (mrsp.done) begin
            acc <= mrsp.r;
            if (sq == 2'd3) begin
              tab_ra <= ewin; state <= S_RD;
            end else begin
              sq <= sq + 2'd1;
              mreq.x <= mrsp.r; mreq.y <= mrsp.r; mreq.start <= 1'b1;
            end
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          mreq.x <= acc; mreq.y <= tab_rd; mreq.start <= 1'b1; state <= S_WMUL;
        end
        S_WMUL: begin
          if (mrsp.done) begin
            acc <= mrsp.r;
            if (win == '0) begin
              res <= mrsp.r; out_ch.valid <= 1'b1; state <= S_IDLE;
            end else begin
              win <= win - 1'b1; sq <= '0;
              mreq.x <= mrsp.r; mreq.y <= mrsp.r; mreq.start <= 1'b1;
              state <= S_SQR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_rdy_idle, clk, rst, in_ch.ready, state == S_IDLE && !busy_mul, "ready while busy")
  `CHK_NEXT(a_inv_start, clk, rst, inv_acc, state == S_TBL, "inverse not started")
  `CHK_IMPL(a_no_wr_rd, clk, rst, state == S_RDW, !tab_we, "table written during window read")
endmodule
`default_nettype wire

// ===== sv/sm2_prime_field_alu_unit.sv =====
// Top level of the SM2 prime field ALU.
// Add, sub and neg give their item in the cycle after acceptance. Mul and square
// run on one shared 32x32 multiplier: 64 partial products, each registered and
// then accumulated, a fold repeated until nothing is left above bit 255, two
// conditional subtractions of p and handoff of the result.
// Inverse builds a 16-entry power table in a synchronous memory (14 multiplies)
// and then runs 64 windows of four squarings and one table multiply, 334
// multiplies in all. One item is in work at a time; the next item is taken once
// the result item has been taken.
`timescale 1ns / 1ps
`default_nettype none
module sm2_prime_field_alu_unit (
  input wire logic clk,
  input wire logic rst,
  sm2_alu_in_if.sink    in_ch,
  sm2_alu_out_if.source out_ch
);
  // sequencer holds the table memory and the multiply unit
  sm2_alu_ctrl u_ctrl (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
endmodule
`default_nettype wire
